// ===== src/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and codes of the register machine instruction executor.
// ----------------------------------------------------------------------------
package rme_pkg;

   localparam int DATA_W = 32;

   typedef logic [3:0] opcode_type;
   typedef logic [1:0] status_type;

   localparam opcode_type OP_ADD     = 4'd0;
   localparam opcode_type OP_MUL     = 4'd1;
   localparam opcode_type OP_SUB     = 4'd2;
   localparam opcode_type OP_DIV     = 4'd3;
   localparam opcode_type OP_COPY    = 4'd4;
   localparam opcode_type OP_LOADIMM = 4'd5;
   localparam opcode_type OP_JMP     = 4'd6;
   localparam opcode_type OP_JMPZERO = 4'd7;
   localparam opcode_type OP_LT      = 4'd8;
   localparam opcode_type OP_GT      = 4'd9;
   localparam opcode_type OP_EQ      = 4'd10;
   localparam opcode_type OP_PRINT   = 4'd11;
   localparam opcode_type OP_LOAD    = 4'd12;
   localparam opcode_type OP_STORE   = 4'd13;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_DIVZERO = 2'd1;
   localparam status_type ST_RANGE   = 2'd2;

endpackage

// ===== src/rme_regfile.sv =====
// ----------------------------------------------------------------------------
// rme_regfile
// Register file RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rme_regfile #(
   parameter int DEPTH = 15,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [rme_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]              rd0_addr,
   input  logic [AW-1:0]              rd1_addr,
   output logic [rme_pkg::DATA_W-1:0] rd0_data,
   output logic [rme_pkg::DATA_W-1:0] rd1_data
);

   logic [rme_pkg::DATA_W-1:0] mem [DEPTH];
   logic [rme_pkg::DATA_W-1:0] rd0_ff;
   logic [rme_pkg::DATA_W-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule

// ===== src/rme_datamem.sv =====
// ----------------------------------------------------------------------------
// rme_datamem
// Data memory RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rme_datamem #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [rme_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [rme_pkg::DATA_W-1:0] rd_data
);

   logic [rme_pkg::DATA_W-1:0] mem [DEPTH];
   logic [rme_pkg::DATA_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== src/rme_divider.sv =====
// ----------------------------------------------------------------------------
// rme_divider
// Signed truncating divider, restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rme_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rme_pkg::DATA_W-1:0] dividend,
   input  logic [rme_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [rme_pkg::DATA_W-1:0] quotient
);

   localparam int W  = rme_pkg::DATA_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic          neg_ff, neg_in;

   logic [W:0]    shifted;
   logic [W+1:0]  diff;

   always_comb begin
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[W-1] ? -dividend : dividend;
         dvs_in  = divisor[W-1] ? -divisor : divisor;
         neg_in  = dividend[W-1] ^ divisor[W-1];
      end else if (busy_ff) begin
         if (diff[W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

// ===== src/register_machine_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// register_machine_instruction_executor: one instruction per beat, state in two RAMs.
// A request is taken only in idle, then passes read (registered RAM reads), execute (retire)
// and finish; a divide waits in a divide state for the bit-serial divider. rsp_stall holds finish.
// After reset both RAMs are zeroed in the clear state, req_stall high.
// ----------------------------------------------------------------------------
module register_machine_instruction_executor #(
   parameter int NUM_REGS  = 15,
   parameter int MEM_WORDS = 1024,
   parameter int PROG_SIZE = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic [11:0]        req_field_a,
   input  logic signed [31:0] req_field_b,
   input  logic [3:0]         req_field_c,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [12:0]        rsp_next_pc,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_print_valid,
   output logic [1:0]         rsp_status
);

   localparam int W     = rme_pkg::DATA_W;
   localparam int RW    = $clog2(NUM_REGS);
   localparam int AW    = $clog2(MEM_WORDS);
   localparam int PCW   = $clog2(PROG_SIZE);
   localparam int CLR_N = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
   localparam int CW    = $clog2(CLR_N);

   localparam logic [31:0] NREG_LIM = 32'(NUM_REGS);
   localparam logic [31:0] MEM_LIM  = 32'(MEM_WORDS);
   localparam logic [31:0] PROG_LIM = 32'(PROG_SIZE);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_EXEC   = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          clr_ff, clr_in;
   logic [PCW-1:0]         pc_ff, pc_in;
   rme_pkg::opcode_type    op_ff, op_in;
   logic [11:0]            a_ff, a_in;
   logic [31:0]            b_ff, b_in;
   logic [3:0]             c_ff, c_in;

   logic [12:0]            res_next_ff, res_next_in;
   logic [W-1:0]           res_value_ff, res_value_in;
   logic                   res_print_ff, res_print_in;
   rme_pkg::status_type    res_status_ff, res_status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [12:0]            rsp_next_ff, rsp_next_in;
   logic [W-1:0]           rsp_value_ff, rsp_value_in;
   logic                   rsp_print_ff, rsp_print_in;
   rme_pkg::status_type    rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   clr_mem, clr_reg;
   logic                   fin_go;
   logic                   ok_a, ok_b, ok_c;
   logic [PCW:0]           pc_inc;

   logic [W-1:0]           x, y, mem_q, div_q;
   logic                   div_done;

   rme_pkg::status_type    ex_status;
   logic [W-1:0]           ex_value;
   logic                   ex_print;
   logic [PCW:0]           ex_next;
   logic                   ex_rf_we, ex_mem_we, ex_div;

   logic [PCW:0]           commit_next;
   logic                   commit;

   logic                   rf_we;
   logic [RW-1:0]          rf_wa, rf_ra0;
   logic [W-1:0]           rf_wd;
   logic                   mem_we;
   logic [AW-1:0]          mem_wa;
   logic [W-1:0]           mem_wd;

   assign accept  = req_valid && !req_stall;
   assign clr_mem = (state_ff == S_CLEAR) && (32'(clr_ff) < MEM_LIM);
   assign clr_reg = (state_ff == S_CLEAR) && (32'(clr_ff) < NREG_LIM);

   assign ok_a   = 32'(a_ff) < NREG_LIM;
   assign ok_b   = b_ff < NREG_LIM;
   assign ok_c   = 32'(c_ff) < NREG_LIM;
   assign pc_inc = {1'b0, pc_ff} + (PCW+1)'(1);

   assign rf_ra0 = ((op_ff == rme_pkg::OP_JMPZERO) || (op_ff == rme_pkg::OP_PRINT))
                   ? RW'(a_ff) : RW'(b_ff);

   always_comb begin
      ex_status = rme_pkg::ST_OK;
      ex_value  = '0;
      ex_print  = 1'b0;
      ex_next   = pc_inc;
      ex_rf_we  = 1'b0;
      ex_mem_we = 1'b0;
      ex_div    = 1'b0;
      unique case (op_ff) inside
         rme_pkg::OP_ADD, rme_pkg::OP_MUL, rme_pkg::OP_SUB, rme_pkg::OP_DIV,
         rme_pkg::OP_LT, rme_pkg::OP_GT, rme_pkg::OP_EQ: begin
            if (!(ok_a && ok_b && ok_c)) begin
               ex_status = rme_pkg::ST_RANGE;
            end else begin
               ex_rf_we = 1'b1;
               case (op_ff)
                  rme_pkg::OP_ADD: ex_value = x + y;
                  rme_pkg::OP_MUL: ex_value = x * y;
                  rme_pkg::OP_SUB: ex_value = x - y;
                  rme_pkg::OP_DIV: begin
                     ex_rf_we = 1'b0;
                     if (y == '0) begin
                        ex_status = rme_pkg::ST_DIVZERO;
                     end else begin
                        ex_div = 1'b1;
                     end
                  end
                  rme_pkg::OP_LT: ex_value = W'($signed(x) < $signed(y));
                  rme_pkg::OP_GT: ex_value = W'($signed(x) > $signed(y));
                  default:        ex_value = W'(x == y);
               endcase
            end
         end
         rme_pkg::OP_COPY: begin
            if (!(ok_a && ok_b)) begin
               ex_status = rme_pkg::ST_RANGE;
            end else begin
               ex_value = x;
               ex_rf_we = 1'b1;
            end
         end
         rme_pkg::OP_LOADIMM: begin
            if (!ok_a) begin
               ex_status = rme_pkg::ST_RANGE;
            end else begin
               ex_value = b_ff;
               ex_rf_we = 1'b1;
            end
         end
         rme_pkg::OP_JMP: begin
            if (32'(a_ff) >= PROG_LIM) begin
               ex_status = rme_pkg::ST_RANGE;
            end else begin
               ex_next = (PCW+1)'(a_ff);
            end
         end
         rme_pkg::OP_JMPZERO: begin
            if (!ok_a) begin
               ex_status = rme_pkg::ST_RANGE;
            end else if (x == '0) begin
               if (b_ff >= PROG_LIM) begin
                  ex_status = rme_pkg::ST_RANGE;
               end else begin
                  ex_next = (PCW+1)'(b_ff);
               end
            end
         end
         rme_pkg::OP_PRINT: begin
            if (!ok_a) begin
               ex_status = rme_pkg::ST_RANGE;
            end else begin
               ex_value = x;
               ex_print = 1'b1;
            end
         end
         rme_pkg::OP_LOAD: begin
            if (!ok_a || (b_ff >= MEM_LIM)) begin
               ex_status = rme_pkg::ST_RANGE;
            end else begin
               ex_value = mem_q;
               ex_rf_we = 1'b1;
            end
         end
         rme_pkg::OP_STORE: begin
            if ((32'(a_ff) >= MEM_LIM) || !ok_b) begin
               ex_status = rme_pkg::ST_RANGE;
            end else begin
               ex_value  = x;
               ex_mem_we = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // retire point: architectural state and the pending result update here
   assign commit      = ((state_ff == S_EXEC) && !ex_div) || ((state_ff == S_DIV) && div_done);
   assign commit_next = (state_ff == S_DIV) ? pc_inc : ex_next;

   assign rf_we  = clr_reg || ((state_ff == S_EXEC) && ex_rf_we) ||
                   ((state_ff == S_DIV) && div_done);
   assign rf_wa  = clr_reg ? RW'(clr_ff) : RW'(a_ff);
   assign rf_wd  = clr_reg ? '0 : ((state_ff == S_DIV) ? div_q : ex_value);
   assign mem_we = clr_mem || ((state_ff == S_EXEC) && ex_mem_we);
   assign mem_wa = clr_mem ? AW'(clr_ff) : AW'(a_ff);
   assign mem_wd = clr_mem ? '0 : x;

   assign fin_go = (state_ff == S_FINISH) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pc_in         = pc_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      res_next_in   = res_next_ff;
      res_value_in  = res_value_ff;
      res_print_in  = res_print_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_next_in   = rsp_next_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_print_in  = rsp_print_ff;
      rsp_status_in = rsp_status_ff;

      if (accept) begin
         op_in = req_opcode;
         a_in  = req_field_a;
         b_in  = req_field_b;
         c_in  = req_field_c;
      end

      if (commit) begin
         res_next_in   = 13'(commit_next);
         res_value_in  = (state_ff == S_DIV) ? div_q : ex_value;
         res_print_in  = (state_ff == S_DIV) ? 1'b0 : ex_print;
         res_status_in = (state_ff == S_DIV) ? rme_pkg::ST_OK : ex_status;
         pc_in         = (32'(commit_next) < PROG_LIM) ? commit_next[PCW-1:0] : '0;
      end

      if (fin_go) begin
         rsp_valid_in  = 1'b1;
         rsp_next_in   = res_next_ff;
         rsp_value_in  = res_value_ff;
         rsp_print_in  = res_print_ff;
         rsp_status_in = res_status_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ:   state_in = S_EXEC;
         S_EXEC:   state_in = ex_div ? S_DIV : S_FINISH;
         S_DIV: begin
            if (div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (fin_go) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      res_next_ff   <= res_next_in;
      res_value_ff  <= res_value_in;
      res_print_ff  <= res_print_in;
      res_status_ff <= res_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_print_ff  <= rsp_print_in;
      rsp_status_ff <= rsp_status_in;
   end

   rme_regfile #(
      .DEPTH (NUM_REGS)
   ) u_regfile (
      .clock    (clock),
      .wr_en    (rf_we),
      .wr_addr  (rf_wa),
      .wr_data  (rf_wd),
      .rd0_addr (rf_ra0),
      .rd1_addr (RW'(c_ff)),
      .rd0_data (x),
      .rd1_data (y)
   );

   rme_datamem #(
      .DEPTH (MEM_WORDS)
   ) u_datamem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (AW'(b_ff)),
      .rd_data (mem_q)
   );

   rme_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == S_EXEC) && ex_div),
      .dividend (x),
      .divisor  (y),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_next_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_print_valid = rsp_print_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
